### rtl/core/elevator_car_controller_core_defines.svh
// ----------------------------------------------------------------------------
// elevator car controller core: assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_CAR_CONTROLLER_CORE_DEFINES_SVH
`define ELEVATOR_CAR_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define ECC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// types, codes and the microcode program of the elevator car controller
// ----------------------------------------------------------------------------
`default_nettype none

package ecc_pkg;

  localparam int MAX_FLOORS_DEF = 32;
  localparam int FLOOR_CAP      = 32;
  localparam logic [5:0] FLOOR_COUNT_RST = 6'd25;

  // button kinds
  localparam logic [2:0] KIND_CALL      = 3'd0;
  localparam logic [2:0] KIND_TOGGLE    = 3'd1;
  localparam logic [2:0] KIND_INSP_UP   = 3'd2;
  localparam logic [2:0] KIND_INSP_DOWN = 3'd3;
  localparam logic [2:0] KIND_OPEN      = 3'd4;
  localparam logic [2:0] KIND_CLOSE     = 3'd5;
  localparam logic [2:0] KIND_CLR_FAULT = 3'd6;

  // car states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UP    = 3'd1;
  localparam logic [2:0] ST_DOWN  = 3'd2;
  localparam logic [2:0] ST_DOOR  = 3'd3;
  localparam logic [2:0] ST_FAULT = 3'd4;

  // fault codes
  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_DOOR = 2'd1;
  localparam logic [1:0] FLT_INSP = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] target_floor;
  } ecc_in_t;

  typedef struct packed {
    logic [4:0] floor;
    logic [2:0] car_state;
    logic       inspection_mode;
    logic       door_is_open;
    logic [1:0] fault;
    logic       rejected;
    logic       last;
  } ecc_out_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_STEP,
    OP_OPEN,
    OP_CLOSE,
    OP_TOGGLE,
    OP_INSP_MOVE,
    OP_CLR_FAULT,
    OP_FLT_INSP,
    OP_FLT_DOOR,
    OP_STATUS,
    OP_REJECT
  } ecc_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_MODE,
    C_NOT_MODE,
    C_BLOCKED,
    C_AT_TGT,
    C_DOOR
  } ecc_cond_t;

  // microcode addresses
  typedef enum logic [3:0] {
    UA_FETCH       = 4'd0,
    UA_CALL        = 4'd1,
    UA_CALL_CHK    = 4'd2,
    UA_WALK        = 4'd3,
    UA_WALK_DOOR   = 4'd4,
    UA_ARRIVE_OPEN = 4'd5,
    UA_CLOSE       = 4'd6,
    UA_TOGGLE      = 4'd7,
    UA_INSP        = 4'd8,
    UA_INSP_DOOR   = 4'd9,
    UA_OPEN        = 4'd10,
    UA_CLR_FAULT   = 4'd11,
    UA_FLT_INSP    = 4'd12,
    UA_FLT_DOOR    = 4'd13,
    UA_STATUS      = 4'd14,
    UA_REJECT      = 4'd15
  } ecc_uaddr_t;

  // control word: jump to jaddr when cond holds, else run op and go to naddr
  typedef struct packed {
    ecc_cond_t  cond;
    ecc_uaddr_t jaddr;
    ecc_op_t    op;
    logic       emit;
    logic       last;
    ecc_uaddr_t naddr;
  } ecc_uword_t;

  typedef struct packed {
    logic mode;
    logic blocked;
    logic at_tgt;
    logic door;
  } ecc_flags_t;

  function automatic ecc_uword_t uw(ecc_cond_t c, ecc_uaddr_t j, ecc_op_t o,
                                    logic e, logic l, ecc_uaddr_t n);
    ecc_uword_t w;
    w.cond  = c;
    w.jaddr = j;
    w.op    = o;
    w.emit  = e;
    w.last  = l;
    w.naddr = n;
    return w;
  endfunction

  function automatic ecc_uword_t ucode_rom(ecc_uaddr_t a);
    ecc_uword_t w;
    case (a)
      UA_FETCH:       w = uw(C_NEVER,    UA_FETCH,       OP_NOP,       1'b0, 1'b0, UA_FETCH);
      UA_CALL:        w = uw(C_MODE,     UA_FLT_INSP,    OP_NOP,       1'b0, 1'b0, UA_CALL_CHK);
      UA_CALL_CHK:    w = uw(C_BLOCKED,  UA_STATUS,      OP_NOP,       1'b0, 1'b0, UA_WALK);
      UA_WALK:        w = uw(C_AT_TGT,   UA_ARRIVE_OPEN, OP_NOP,       1'b0, 1'b0, UA_WALK_DOOR);
      UA_WALK_DOOR:   w = uw(C_DOOR,     UA_FLT_DOOR,    OP_STEP,      1'b1, 1'b0, UA_WALK);
      UA_ARRIVE_OPEN: w = uw(C_NEVER,    UA_FETCH,       OP_OPEN,      1'b1, 1'b0, UA_CLOSE);
      UA_CLOSE:       w = uw(C_NEVER,    UA_FETCH,       OP_CLOSE,     1'b1, 1'b1, UA_FETCH);
      UA_TOGGLE:      w = uw(C_NEVER,    UA_FETCH,       OP_TOGGLE,    1'b1, 1'b1, UA_FETCH);
      UA_INSP:        w = uw(C_NOT_MODE, UA_REJECT,      OP_NOP,       1'b0, 1'b0, UA_INSP_DOOR);
      UA_INSP_DOOR:   w = uw(C_DOOR,     UA_FLT_DOOR,    OP_INSP_MOVE, 1'b1, 1'b1, UA_FETCH);
      UA_OPEN:        w = uw(C_NEVER,    UA_FETCH,       OP_OPEN,      1'b1, 1'b1, UA_FETCH);
      UA_CLR_FAULT:   w = uw(C_NEVER,    UA_FETCH,       OP_CLR_FAULT, 1'b1, 1'b1, UA_FETCH);
      UA_FLT_INSP:    w = uw(C_NEVER,    UA_FETCH,       OP_FLT_INSP,  1'b1, 1'b1, UA_FETCH);
      UA_FLT_DOOR:    w = uw(C_NEVER,    UA_FETCH,       OP_FLT_DOOR,  1'b1, 1'b1, UA_FETCH);
      UA_STATUS:      w = uw(C_NEVER,    UA_FETCH,       OP_STATUS,    1'b1, 1'b1, UA_FETCH);
      UA_REJECT:      w = uw(C_NEVER,    UA_FETCH,       OP_REJECT,    1'b1, 1'b1, UA_FETCH);
      default:        w = uw(C_NEVER,    UA_FETCH,       OP_NOP,       1'b0, 1'b0, UA_FETCH);
    endcase
    return w;
  endfunction

  // program entry for each button kind
  function automatic ecc_uaddr_t entry_addr(logic [2:0] kind);
    ecc_uaddr_t a;
    case (kind)
      KIND_CALL:      a = UA_CALL;
      KIND_TOGGLE:    a = UA_TOGGLE;
      KIND_INSP_UP:   a = UA_INSP;
      KIND_INSP_DOWN: a = UA_INSP;
      KIND_OPEN:      a = UA_OPEN;
      KIND_CLOSE:     a = UA_CLOSE;
      KIND_CLR_FAULT: a = UA_CLR_FAULT;
      default:        a = UA_STATUS;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/core/elevator_car_controller_core.sv
// ----------------------------------------------------------------------------
// elevator_car_controller_core
// button-event elevator car controller driven by a microcoded sequencer
// ----------------------------------------------------------------------------
// result words are registered; a new event word is accepted only once the
// sequencer is back at fetch after the last result word of the previous event;
// the sequencer runs one control word per cycle unless an output stall holds it
// at the emitting word
// reset (rst_n low, synchronous): floor 0, idle, normal mode, no fault,
// door closed, floor count 25, no output word pending
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_car_controller_core
  import ecc_pkg::*;
#(
  parameter int MAX_FLOORS = MAX_FLOORS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // event words
  input  logic       in_valid,
  output logic       in_ready,
  input  ecc_in_t    in_data,
  // result words
  output logic       out_valid,
  input  logic       out_ready,
  output ecc_out_t   out_data,
  // floor count register
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);

  `include "elevator_car_controller_core_defines.svh"

  // effective floor count is capped by the parameter and by 32
  localparam int         CAP_I = (MAX_FLOORS < FLOOR_CAP) ? MAX_FLOORS : FLOOR_CAP;
  localparam logic [5:0] CAP   = 6'(CAP_I);

  // configuration and car status
  logic [5:0] floor_count_r;
  logic [4:0] floor_r,  floor_nxt;
  logic [2:0] state_r,  state_nxt;
  logic       mode_r,   mode_nxt;
  logic [1:0] fault_r,  fault_nxt;
  logic       door_r,   door_nxt;

  // latched event word
  logic [2:0] kind_r;
  logic [5:0] tgt_r;

  // output register
  logic       out_valid_r;
  ecc_out_t   out_r;

  logic       in_fire;
  logic       emit_ok;
  logic       fetch;
  logic       exec;
  ecc_uword_t uword;
  ecc_flags_t flags;
  logic [5:0] eff_cnt;
  logic       going_up;
  logic [2:0] shown_state;

  assign in_fire = in_valid && in_ready;
  assign in_ready = fetch;
  // output slot is free when empty or being drained this cycle
  assign emit_ok = !out_valid_r || out_ready;

  assign eff_cnt  = (floor_count_r > CAP) ? CAP : floor_count_r;
  assign going_up = tgt_r > {1'b0, floor_r};

  // condition flags sampled by the sequencer
  always_comb begin
    flags.mode    = mode_r;
    flags.blocked = (fault_r != FLT_NONE) || (tgt_r >= eff_cnt);
    flags.at_tgt  = ({1'b0, floor_r} == tgt_r);
    flags.door    = door_r;
  end

  ecc_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .kind    (in_data.kind),
    .flags   (flags),
    .emit_ok (emit_ok),
    .fetch   (fetch),
    .uword   (uword),
    .exec    (exec)
  );

  // datapath: one operation per executed control word
  always_comb begin
    floor_nxt   = floor_r;
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    fault_nxt   = fault_r;
    door_nxt    = door_r;
    shown_state = state_r;
    if (exec) begin
      case (uword.op)
        OP_STEP: begin
          // one floor toward the target; the stored state rests idle
          floor_nxt   = going_up ? (floor_r + 5'd1) : (floor_r - 5'd1);
          state_nxt   = ST_IDLE;
        end
        OP_OPEN: begin
          // stored state is never a moving state, so opening always succeeds
          door_nxt  = 1'b1;
          state_nxt = ST_DOOR;
        end
        OP_CLOSE: begin
          door_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
        OP_TOGGLE: begin
          mode_nxt = !mode_r;
        end
        OP_INSP_MOVE: begin
          // saturating inspection move, up limited to the top served floor
          if (kind_r == KIND_INSP_UP) begin
            if (({1'b0, floor_r} + 6'd1) < eff_cnt) begin
              floor_nxt = floor_r + 5'd1;
            end
          end else if (floor_r != 5'd0) begin
            floor_nxt = floor_r - 5'd1;
          end
        end
        OP_CLR_FAULT: begin
          fault_nxt = FLT_NONE;
          state_nxt = ST_IDLE;
        end
        OP_FLT_INSP: begin
          fault_nxt = FLT_INSP;
          state_nxt = ST_FAULT;
        end
        OP_FLT_DOOR: begin
          fault_nxt = FLT_DOOR;
          state_nxt = ST_FAULT;
        end
        default: begin
        end
      endcase
      // a floor step reports its direction instead of the stored state
      shown_state = (uword.op == OP_STEP) ? (going_up ? ST_UP : ST_DOWN) : state_nxt;
    end
  end

  // status and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_count_r <= FLOOR_COUNT_RST;
      floor_r       <= 5'd0;
      state_r       <= ST_IDLE;
      mode_r        <= 1'b0;
      fault_r       <= FLT_NONE;
      door_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        floor_count_r <= cfg_wdata;
      end
      floor_r <= floor_nxt;
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      fault_r <= fault_nxt;
      door_r  <= door_nxt;
      if (exec && uword.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_data.kind;
      tgt_r  <= in_data.target_floor;
    end
    if (exec && uword.emit) begin
      out_r.floor           <= floor_nxt;
      out_r.car_state       <= shown_state;
      out_r.inspection_mode <= mode_nxt;
      out_r.door_is_open    <= door_nxt;
      out_r.fault           <= fault_nxt;
      out_r.rejected        <= (uword.op == OP_REJECT);
      out_r.last            <= uword.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a fault stop always carries a fault code
  `ECC_ASSERT_NOW(a_fault_code, state_r == ST_FAULT, fault_r != FLT_NONE, "fault stop without code")
  // an accepted word always starts a program
  `ECC_ASSERT_NEXT(a_leave_fetch, in_fire, !in_ready, "sequencer stayed at fetch")
  // the final word of an event returns the sequencer to fetch
  `ECC_ASSERT_NEXT(a_last_fetch, exec && uword.emit && uword.last, in_ready, "no fetch after last")
  // a new result word is only written into a free output slot
  `ECC_ASSERT_NOW(a_slot_free, exec && uword.emit, emit_ok, "output word overwritten")

endmodule

`default_nettype wire

### rtl/core/ecc_useq.sv
// ----------------------------------------------------------------------------
// ecc_useq
// microcode sequencer: step counter, program rom and conditional jumps
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_useq
  import ecc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [2:0] kind,
  input  ecc_flags_t flags,
  input  logic       emit_ok,
  output logic       fetch,
  output ecc_uword_t uword,
  output logic       exec
);

  ecc_uaddr_t upc_r, upc_nxt;
  logic       cond_hit;

  assign uword = ucode_rom(upc_r);
  assign fetch = (upc_r == UA_FETCH);

  always_comb begin
    case (uword.cond)
      C_MODE:     cond_hit = flags.mode;
      C_NOT_MODE: cond_hit = !flags.mode;
      C_BLOCKED:  cond_hit = flags.blocked;
      C_AT_TGT:   cond_hit = flags.at_tgt;
      C_DOOR:     cond_hit = flags.door;
      default:    cond_hit = 1'b0;
    endcase
  end

  // an emitting word waits for a free output slot
  assign exec = !fetch && !cond_hit && (!uword.emit || emit_ok);

  always_comb begin
    if (fetch) begin
      upc_nxt = in_fire ? entry_addr(kind) : UA_FETCH;
    end else if (cond_hit) begin
      upc_nxt = uword.jaddr;
    end else if (exec) begin
      upc_nxt = uword.naddr;
    end else begin
      upc_nxt = upc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator car controller testbench
// drives button event words with random gaps and output stalls, predicts every
// result word from a behavioral copy of the car, and checks each result word
// field by field across several floor count settings
// ----------------------------------------------------------------------------

module testbench
  import ecc_pkg::*;
;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int IDLE_PCT       = 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 2000;

  // behavioral car model plus the queue of result words still owed
  class car_scoreboard;
    logic [5:0] floor_count;
    logic [4:0] car_floor;
    logic [2:0] car_state;
    logic       insp_mode;
    logic [1:0] fault_code;
    logic       door_flag;
    ecc_out_t   expected_words[$];
    int         errors;

    function new();
      floor_count = FLOOR_COUNT_RST;
      car_floor   = '0;
      car_state   = ST_IDLE;
      insp_mode   = 1'b0;
      fault_code  = FLT_NONE;
      door_flag   = 1'b0;
      errors      = 0;
    endfunction

    function int effective_floors();
      return (floor_count > 6'd32) ? 32 : int'(floor_count);
    endfunction

    function void push_word(logic [2:0] shown_state, logic rej);
      ecc_out_t w;
      w.floor           = car_floor;
      w.car_state       = shown_state;
      w.inspection_mode = insp_mode;
      w.door_is_open    = door_flag;
      w.fault           = fault_code;
      w.rejected        = rej;
      w.last            = 1'b0;
      expected_words.push_back(w);
    endfunction

    function void enter_fault(logic [1:0] code);
      fault_code = code;
      car_state  = ST_FAULT;
    endfunction

    function void open_door();
      if (car_state == ST_UP || car_state == ST_DOWN) begin
        enter_fault(FLT_DOOR);
      end else begin
        door_flag = 1'b1;
        car_state = ST_DOOR;
      end
    endfunction

    function void note_event(ecc_in_t ev);
      int       cnt;
      logic     going_up;
      ecc_out_t w;
      cnt = effective_floors();
      case (ev.kind)
        KIND_CALL: begin
          if (insp_mode) begin
            enter_fault(FLT_INSP);
            push_word(car_state, 1'b0);
          end else if (fault_code != FLT_NONE || int'(ev.target_floor) >= cnt) begin
            push_word(car_state, 1'b0);
          end else begin
            going_up = ev.target_floor > {1'b0, car_floor};
            // one word per floor step, the door fault ends the walk
            while ({1'b0, car_floor} != ev.target_floor && car_state != ST_FAULT) begin
              if (door_flag) begin
                enter_fault(FLT_DOOR);
                push_word(car_state, 1'b0);
              end else begin
                car_floor = going_up ? car_floor + 5'd1 : car_floor - 5'd1;
                car_state = ST_IDLE;
                push_word(going_up ? ST_UP : ST_DOWN, 1'b0);
              end
            end
            if (car_state != ST_FAULT) begin
              open_door();
              push_word(car_state, 1'b0);
              door_flag = 1'b0;
              car_state = ST_IDLE;
              push_word(car_state, 1'b0);
            end
          end
        end
        KIND_TOGGLE: begin
          insp_mode = ~insp_mode;
          push_word(car_state, 1'b0);
        end
        KIND_INSP_UP, KIND_INSP_DOWN: begin
          if (!insp_mode) begin
            push_word(car_state, 1'b1);
          end else begin
            if (door_flag) begin
              enter_fault(FLT_DOOR);
            end else if (ev.kind == KIND_INSP_UP) begin
              if (cnt >= 1 && int'(car_floor) < cnt - 1) car_floor = car_floor + 5'd1;
            end else begin
              if (car_floor != 5'd0) car_floor = car_floor - 5'd1;
            end
            push_word(car_state, 1'b0);
          end
        end
        KIND_OPEN: begin
          open_door();
          push_word(car_state, 1'b0);
        end
        KIND_CLOSE: begin
          door_flag = 1'b0;
          car_state = ST_IDLE;
          push_word(car_state, 1'b0);
        end
        KIND_CLR_FAULT: begin
          fault_code = FLT_NONE;
          car_state  = ST_IDLE;
          push_word(car_state, 1'b0);
        end
        default: begin
          push_word(car_state, 1'b0);
        end
      endcase
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(ecc_out_t got);
      ecc_out_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with none expected, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("floor", want.floor, got.floor);
      compare_field("car_state", want.car_state, got.car_state);
      compare_field("inspection_mode", want.inspection_mode, got.inspection_mode);
      compare_field("door_is_open", want.door_is_open, got.door_is_open);
      compare_field("fault", want.fault, got.fault);
      compare_field("rejected", want.rejected, got.rejected);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  ecc_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ecc_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;

  logic       calm = 1'b0;
  logic       rx_hold_req = 1'b0;
  logic       rx_hold_used = 1'b0;
  int         rx_hold_left = 0;
  int         quiet_cycles = 0;

  car_scoreboard sb;

  elevator_car_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_req && !rx_hold_used) begin
      rx_hold_used <= 1'b1;
      rx_hold_left <= RX_HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  // watchdog on cycles with no word moving in either direction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic ecc_in_t make_event(logic [2:0] k, logic [5:0] tgt);
    ecc_in_t ev;
    ev.kind         = k;
    ev.target_floor = tgt;
    return ev;
  endfunction

  // mostly reachable calls, with enough clears and closes to keep the car moving
  function automatic ecc_in_t random_event();
    int         roll;
    int         cnt;
    logic [2:0] k;
    logic [5:0] tgt;
    roll = $urandom_range(0, 99);
    cnt  = sb.effective_floors();
    tgt  = 6'($urandom_range(0, 63));
    if (roll < 45) begin
      k = KIND_CALL;
      if (cnt > 0 && $urandom_range(0, 99) < 85) tgt = 6'($urandom_range(0, cnt - 1));
      if (sb.insp_mode && $urandom_range(0, 99) < 60) k = KIND_TOGGLE;
    end else if (roll < 51) begin
      k = KIND_TOGGLE;
    end else if (roll < 63) begin
      k = roll[0] ? KIND_INSP_UP : KIND_INSP_DOWN;
    end else if (roll < 71) begin
      k = KIND_OPEN;
    end else if (roll < 81) begin
      k = KIND_CLOSE;
    end else if (roll < 95) begin
      k = KIND_CLR_FAULT;
    end else begin
      k = KIND_UNUSED;
    end
    return make_event(k, tgt);
  endfunction

  task automatic send_event(ecc_in_t ev);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_event(ev);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_floor_count(logic [5:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.floor_count = value;
  endtask

  logic [5:0] phase_floors [8] = '{6'd2, 6'd32, 6'd63, 6'd0, 6'd1, 6'd9, 6'd25, 6'd17};
  int         phase_items  [8] = '{40, 80, 60, 30, 30, 70, 70, 50};

  initial begin
    int p;
    int i;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk at the reset floor count
    send_event(make_event(KIND_CALL, 6'd0));
    send_event(make_event(KIND_CALL, 6'd24));
    send_event(make_event(KIND_CALL, 6'd25));
    send_event(make_event(KIND_CALL, 6'd63));
    send_event(make_event(KIND_INSP_UP, 6'd0));
    send_event(make_event(KIND_INSP_DOWN, 6'd63));
    send_event(make_event(KIND_OPEN, 6'd0));
    send_event(make_event(KIND_CALL, 6'd3));
    send_event(make_event(KIND_CALL, 6'd5));
    send_event(make_event(KIND_CLOSE, 6'd0));
    send_event(make_event(KIND_CLR_FAULT, 6'd0));
    send_event(make_event(KIND_CALL, 6'd0));
    send_event(make_event(KIND_TOGGLE, 6'd0));
    send_event(make_event(KIND_CALL, 6'd4));
    send_event(make_event(KIND_INSP_DOWN, 6'd0));
    send_event(make_event(KIND_INSP_UP, 6'd0));
    send_event(make_event(KIND_OPEN, 6'd0));
    send_event(make_event(KIND_INSP_UP, 6'd0));
    send_event(make_event(KIND_CLOSE, 6'd0));
    send_event(make_event(KIND_CLR_FAULT, 6'd0));
    send_event(make_event(KIND_UNUSED, 6'h2a));
    send_event(make_event(KIND_TOGGLE, 6'd0));
    send_event(make_event(KIND_CALL, 6'd20));

    for (p = 0; p < 8; p++) begin
      write_floor_count(phase_floors[p]);
      calm <= (p == 5);
      // car parked above the new top floor, called back down
      if (p == 0) send_event(make_event(KIND_CALL, 6'd1));
      for (i = 0; i < phase_items[p]; i++) begin
        if (p == 1 && i == 5) rx_hold_req <= 1'b1;
        if (p == 6 && i == 35) drain_results();
        send_event(random_event());
      end
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ecc_pkg.sv
rtl/core/ecc_useq.sv
rtl/core/elevator_car_controller_core.sv
bench/testbench.sv
